// File: src/cal_pkg.sv
package cal_pkg;

    localparam int DEPTH_DEF  = 64;
    localparam int DATA_W_DEF = 32;

    typedef enum logic [2:0] {
        MD_INS_BEFORE = 3'd0,
        MD_INS_AFTER  = 3'd1,
        MD_DELETE     = 3'd2,
        MD_PREV       = 3'd3,
        MD_NEXT       = 3'd4,
        MD_FIRST      = 3'd5,
        MD_LAST       = 3'd6,
        MD_READ       = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

// File: src/cal_ctrl.sv
module cal_ctrl
    import cal_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.load       = 1'b0;
        cmd.exec       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_exec_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (state_reg == S_EXEC))
        else $error("exec issued outside exec state");
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("accepted item not executed next");
    a_exec_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("executed item gives no result");
`endif

endmodule

// File: src/cal_datapath.sv
module cal_datapath
    import cal_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic [2:0]         mode,
    input  logic signed [31:0] value,
    input  logic [5:0]         index,
    output logic [1:0]         status,
    output logic               moved,
    output logic signed [31:0] data,
    output logic [6:0]         count
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;

    mode_t                    mode_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [5:0]               idx_reg;
    logic [DATA_W-1:0]        cells [DEPTH];
    logic [DATA_W-1:0]        below [DEPTH];
    logic [DATA_W-1:0]        above [DEPTH];
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [PW-1:0]            cur_reg;
    logic [PW-1:0]            cur_next;
    status_t                  st_reg;
    status_t                  st_next;
    logic                     moved_reg;
    logic                     moved_next;
    logic signed [31:0]       data_reg;
    logic [6:0]               cnt_out_reg;

    logic signed [63:0]       value_ext;
    logic                     empty;
    logic                     full;
    logic [PW-1:0]            last;
    logic [PW-1:0]            rd_addr;
    logic                     use_zero;
    logic                     use_val;
    logic                     do_ins;
    logic                     do_del;
    logic [PW-1:0]            ins_pos;
    logic [CMPW-1:0]          idx_w;
    logic signed [DATA_W-1:0] rd_sel;
    logic signed [63:0]       rd_ext;

    assign value_ext = 64'(value);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode_t'(mode);
            val_reg  <= value_ext[DATA_W-1:0];
            idx_reg  <= index;
        end
    end

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign last  = PW'(count_reg - 1'b1);
    assign idx_w = CMPW'(idx_reg);

    always_comb
    begin
        st_next    = ST_OK;
        moved_next = 1'b0;
        count_next = count_reg;
        cur_next   = cur_reg;
        rd_addr    = cur_reg;
        use_zero   = empty;
        use_val    = 1'b0;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        ins_pos    = cur_reg;
        case (mode_reg)
            MD_INS_BEFORE, MD_INS_AFTER:
            begin
                if (full)
                begin
                    st_next = ST_FULL;
                end
                else if (empty)
                begin
                    do_ins     = 1'b1;
                    ins_pos    = '0;
                    use_val    = 1'b1;
                    use_zero   = 1'b0;
                    count_next = CW'(1);
                    cur_next   = '0;
                end
                else
                begin
                    do_ins     = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (mode_reg == MD_INS_BEFORE)
                    begin
                        cur_next = cur_reg + 1'b1;
                    end
                    else
                    begin
                        ins_pos = cur_reg + 1'b1;
                    end
                end
            end
            MD_DELETE:
            begin
                if (empty)
                begin
                    st_next = ST_EMPTY;
                end
                else
                begin
                    do_del     = 1'b1;
                    count_next = count_reg - 1'b1;
                    if (count_reg == CW'(1))
                    begin
                        cur_next = '0;
                        use_zero = 1'b1;
                    end
                    else if (cur_reg == last)
                    begin
                        cur_next = cur_reg - 1'b1;
                        rd_addr  = cur_reg - 1'b1;
                    end
                    else
                    begin
                        rd_addr = cur_reg + 1'b1;
                    end
                end
            end
            MD_PREV:
            begin
                if (empty)
                begin
                    st_next = ST_EMPTY;
                end
                else if (cur_reg != '0)
                begin
                    cur_next   = cur_reg - 1'b1;
                    rd_addr    = cur_reg - 1'b1;
                    moved_next = 1'b1;
                end
            end
            MD_NEXT:
            begin
                if (empty)
                begin
                    st_next = ST_EMPTY;
                end
                else if (cur_reg != last)
                begin
                    cur_next   = cur_reg + 1'b1;
                    rd_addr    = cur_reg + 1'b1;
                    moved_next = 1'b1;
                end
            end
            MD_FIRST:
            begin
                if (empty)
                begin
                    st_next = ST_EMPTY;
                end
                else
                begin
                    cur_next = '0;
                    rd_addr  = '0;
                end
            end
            MD_LAST:
            begin
                if (empty)
                begin
                    st_next = ST_EMPTY;
                end
                else
                begin
                    cur_next = last;
                    rd_addr  = last;
                end
            end
            MD_READ:
            begin
                if (idx_w >= CMPW'(count_reg))
                begin
                    st_next  = ST_RANGE;
                    use_zero = 1'b1;
                end
                else
                begin
                    use_zero = 1'b0;
                    rd_addr  = idx_w[PW-1:0];
                end
            end
            default:
            begin
                st_next = ST_OK;
            end
        endcase
    end

    // neighbor taps for the shifting cells
    generate
        for (genvar g = 0; g < DEPTH; g++)
        begin : g_cell
            localparam logic [PW:0] POS = (PW + 1)'(g);
            if (g == 0)
            begin : g_lo
                assign below[g] = '0;
            end
            else
            begin : g_lo
                assign below[g] = cells[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_hi
                assign above[g] = '0;
            end
            else
            begin : g_hi
                assign above[g] = cells[g+1];
            end
            always_ff @(posedge clk)
            begin
                if (cmd.exec)
                begin
                    if (do_ins && POS == {1'b0, ins_pos})
                    begin
                        cells[g] <= val_reg;
                    end
                    else if (do_ins && POS > {1'b0, ins_pos})
                    begin
                        cells[g] <= below[g];
                    end
                    else if (do_del && POS >= {1'b0, cur_reg})
                    begin
                        cells[g] <= above[g];
                    end
                end
            end
        end
    endgenerate

    assign rd_sel = use_val ? val_reg : $signed(cells[rd_addr]);
    assign rd_ext = 64'(rd_sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cur_reg   <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
            cur_reg   <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            st_reg      <= st_next;
            moved_reg   <= moved_next;
            data_reg    <= use_zero ? 32'sd0 : rd_ext[31:0];
            cnt_out_reg <= 7'(count_next);
        end
    end

    assign status = st_reg;
    assign moved  = moved_reg;
    assign data   = data_reg;
    assign count  = cnt_out_reg;

`ifndef ASSERT_OFF
    a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (CW'(cur_reg) < count_reg))
        else $error("cursor beyond end of list");
    a_empty_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (cur_reg == '0))
        else $error("cursor not at zero on empty list");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count above depth");
`endif

endmodule

// File: src/cursor_array_list.sv
// cursor_array_list: ordered list of up to DEPTH signed elements with a cursor
// input channel: in_valid/in_ready carry mode, value and index for one item
// output channel: out_valid/out_ready carry status, moved, data and count
// every accepted item gives exactly one result item, in order
// an item is accepted in the idle state and then executed in the execute state,
// in which all shifting cells move and the result is registered
// a new item is not accepted until the current one is executed, as set by the
// controller's accept/execute sequence
// in_ready is high while the controller is idle, also while a result waits
// a result waiting in the output register stalls only the execute step of the
// next item; nothing is lost or overwritten while out_ready is low
// reset clears the element count and cursor; the list starts empty, and the
// element cells themselves are not cleared (only entries below count are read)
module cursor_array_list
    import cal_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         mode,
    input  logic signed [31:0] value,
    input  logic [5:0]         index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic               moved,
    output logic signed [31:0] data,
    output logic [6:0]         count
);

    cmd_t cmd;

    cal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    cal_datapath #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .mode   (mode),
        .value  (value),
        .index  (index),
        .status (status),
        .moved  (moved),
        .data   (data),
        .count  (count)
    );

endmodule

// File: tb/tb_top.sv
module tb_top;
    import cal_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam int HOLD_CYCLES = 120;

    typedef struct {
        status_t            st;
        logic               mv;
        logic signed [31:0] dat;
        logic [6:0]         cnt;
    } list_result_t;

    typedef struct {
        mode_t              m;
        logic signed [31:0] v;
        logic [5:0]         ix;
        bit                 typed;
        status_t            st;
        logic               mv;
        logic signed [31:0] dat;
        logic [6:0]         cnt;
    } directed_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic [5:0]         index;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic               moved;
    logic signed [31:0] data;
    logic [6:0]         count;

    logic signed [31:0] list_mem [LIST_DEPTH];
    int                 list_len;
    int                 cursor;
    list_result_t       pending_results [$];
    int                 error_count = 0;
    int                 rx_idle_pct = 0;
    bit                 hold_request = 1'b0;

    // empty-list cases, extremes, cursor walk, read out of range, delete to empty
    directed_row_t directed_plan [24] = '{
        '{MD_READ,       32'sh00000000,  0, 1, ST_RANGE, 0, 32'sh00000000, 0},
        '{MD_DELETE,     32'sh00000000,  0, 1, ST_EMPTY, 0, 32'sh00000000, 0},
        '{MD_PREV,       32'sh00000000,  0, 1, ST_EMPTY, 0, 32'sh00000000, 0},
        '{MD_NEXT,       32'sh00000000,  0, 1, ST_EMPTY, 0, 32'sh00000000, 0},
        '{MD_FIRST,      32'sh00000000,  0, 1, ST_EMPTY, 0, 32'sh00000000, 0},
        '{MD_LAST,       32'sh00000000,  0, 1, ST_EMPTY, 0, 32'sh00000000, 0},
        '{MD_READ,       32'sh00000000, 63, 1, ST_RANGE, 0, 32'sh00000000, 0},
        '{MD_INS_BEFORE, 32'sh7fffffff,  0, 1, ST_OK,    0, 32'sh7fffffff, 1},
        '{MD_INS_AFTER,  32'sh80000000,  0, 1, ST_OK,    0, 32'sh7fffffff, 2},
        '{MD_INS_BEFORE, 32'shffffffff,  0, 0, ST_OK,    0, 32'sh00000000, 0},
        '{MD_NEXT,       32'sh00000000,  0, 0, ST_OK,    0, 32'sh00000000, 0},
        '{MD_NEXT,       32'sh00000000,  0, 0, ST_OK,    0, 32'sh00000000, 0},
        '{MD_PREV,       32'sh00000000,  0, 0, ST_OK,    0, 32'sh00000000, 0},
        '{MD_FIRST,      32'sh00000000,  0, 0, ST_OK,    0, 32'sh00000000, 0},
        '{MD_PREV,       32'sh00000000,  0, 0, ST_OK,    0, 32'sh00000000, 0},
        '{MD_LAST,       32'sh00000000,  0, 0, ST_OK,    0, 32'sh00000000, 0},
        '{MD_READ,       32'sh00000000, 63, 1, ST_RANGE, 0, 32'sh00000000, 3},
        '{MD_READ,       32'sh00000000,  0, 0, ST_OK,    0, 32'sh00000000, 0},
        '{MD_READ,       32'sh00000000,  2, 0, ST_OK,    0, 32'sh00000000, 0},
        '{MD_READ,       32'sh00000000,  3, 1, ST_RANGE, 0, 32'sh00000000, 3},
        '{MD_DELETE,     32'sh00000000,  0, 0, ST_OK,    0, 32'sh00000000, 0},
        '{MD_DELETE,     32'sh00000000,  0, 0, ST_OK,    0, 32'sh00000000, 0},
        '{MD_DELETE,     32'sh00000000,  0, 1, ST_OK,    0, 32'sh00000000, 0},
        '{MD_INS_AFTER,  32'sh0000a5a5,  0, 1, ST_OK,    0, 32'sh0000a5a5, 1}
    };

    cursor_array_list dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .value     (value),
        .index     (index),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .moved     (moved),
        .data      (data),
        .count     (count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic list_result_t list_step(mode_t m, logic signed [31:0] v,
                                               logic [5:0] ix);
        list_result_t r;
        bit           data_done;
        int           i;
        r.st = ST_OK;
        r.mv = 1'b0;
        r.dat = '0;
        data_done = 1'b0;
        case (m)
            MD_INS_BEFORE, MD_INS_AFTER:
            begin
                if (list_len >= LIST_DEPTH)
                begin
                    r.st = ST_FULL;
                end
                else if (list_len == 0)
                begin
                    list_mem[0] = v;
                    cursor = 0;
                    list_len = 1;
                end
                else if (m == MD_INS_BEFORE)
                begin
                    for (i = list_len; i > cursor; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[cursor] = v;
                    cursor++;
                    list_len++;
                end
                else
                begin
                    for (i = list_len; i > cursor + 1; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[cursor + 1] = v;
                    list_len++;
                end
            end
            MD_DELETE:
            begin
                if (list_len == 0)
                begin
                    r.st = ST_EMPTY;
                end
                else
                begin
                    for (i = cursor; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                    if (list_len == 0)
                        cursor = 0;
                    else if (cursor >= list_len)
                        cursor = list_len - 1;
                end
            end
            MD_PREV:
            begin
                if (list_len == 0)
                    r.st = ST_EMPTY;
                else if (cursor > 0)
                begin
                    cursor--;
                    r.mv = 1'b1;
                end
            end
            MD_NEXT:
            begin
                if (list_len == 0)
                    r.st = ST_EMPTY;
                else if (cursor + 1 < list_len)
                begin
                    cursor++;
                    r.mv = 1'b1;
                end
            end
            MD_FIRST:
            begin
                if (list_len == 0)
                    r.st = ST_EMPTY;
                else
                    cursor = 0;
            end
            MD_LAST:
            begin
                if (list_len == 0)
                    r.st = ST_EMPTY;
                else
                    cursor = list_len - 1;
            end
            default:
            begin
                if (int'(ix) >= list_len)
                    r.st = ST_RANGE;
                else
                    r.dat = list_mem[ix];
                data_done = 1'b1;
            end
        endcase
        if (!data_done && list_len > 0)
            r.dat = list_mem[cursor];
        r.cnt = list_len[6:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    // drive one item, wait for its handshake, then queue what it should produce
    task automatic send_item(mode_t m, logic signed [31:0] v, logic [5:0] ix,
                             bit typed, list_result_t typed_res);
        list_result_t r;
        in_valid <= 1'b1;
        mode <= m;
        value <= v;
        index <= ix;
        do
            @(posedge clk);
        while (!in_ready);
        r = list_step(m, v, ix);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_edits(int n, int ins_w, int del_w, int tx_pct);
        list_result_t       none;
        mode_t              m;
        logic signed [31:0] v;
        logic [5:0]         ix;
        int                 r;
        none = '{ST_OK, 1'b0, 32'sh0, 7'd0};
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < ins_w)
                m = ($urandom_range(0, 1) == 0) ? MD_INS_BEFORE : MD_INS_AFTER;
            else if (r < ins_w + del_w)
                m = MD_DELETE;
            else
                m = mode_t'($urandom_range(MD_PREV, MD_READ));
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh7fffffff;
                    1: v = 32'sh80000000;
                    2: v = 32'sh00000000;
                    default: v = 32'shffffffff;
                endcase
            end
            else
            begin
                v = $urandom;
            end
            if (list_len > 0 && $urandom_range(0, 2) != 0)
                ix = 6'($urandom_range(0, list_len - 1));
            else
                ix = 6'($urandom_range(0, 63));
            if ($urandom_range(0, 99) < tx_pct)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            send_item(m, v, ix, 1'b0, none);
        end
    endtask

    initial
    begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if ($urandom_range(0, 99) < rx_idle_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no item pending", {25'd0, count}, 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                    report_mismatch("status", 32'(status), 32'(want.st));
                if (moved !== want.mv)
                    report_mismatch("moved", 32'(moved), 32'(want.mv));
                if (data !== want.dat)
                    report_mismatch("data", data, want.dat);
                if (count !== want.cnt)
                    report_mismatch("count", 32'(count), 32'(want.cnt));
            end
        end
    end

    initial
    begin
        list_result_t typed_res;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        mode <= MD_READ;
        value <= '0;
        index <= '0;
        list_len = 0;
        cursor = 0;
        foreach (list_mem[i])
            list_mem[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rx_idle_pct = 8;
        foreach (directed_plan[i])
        begin
            typed_res = '{directed_plan[i].st, directed_plan[i].mv,
                          directed_plan[i].dat, directed_plan[i].cnt};
            send_item(directed_plan[i].m, directed_plan[i].v, directed_plan[i].ix,
                      directed_plan[i].typed, typed_res);
        end

        // fill to full and keep pushing refused inserts
        random_edits(160, 85, 5, 10);

        // receiver holds off while the sender keeps offering
        rx_idle_pct = 0;
        hold_request = 1'b1;
        random_edits(30, 40, 20, 0);
        drain_results();

        rx_idle_pct = 6;
        random_edits(200, 50, 40, 20);
        random_edits(200, 10, 70, 15);
        drain_results();

        rx_idle_pct = 10;
        random_edits(400, 30, 25, 30);
        rx_idle_pct = 0;
        random_edits(250, 45, 35, 5);
        drain_results();

        rx_idle_pct = 5;
        random_edits(200, 70, 10, 10);

        rx_idle_pct = 0;
        random_edits(180, 35, 35, 0);

        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: cursor_array_list.f
src/cal_pkg.sv
src/cal_ctrl.sv
src/cal_datapath.sv
src/cursor_array_list.sv
tb/tb_top.sv
